// ===== rtl/core/fpe_pkg.sv =====
`timescale 1ns / 1ps

package fpe_pkg;

  // fixed field widths
  localparam int unsigned ElemWidth       = 32;
  localparam int unsigned CoefWidth       = 32;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned MatDepth        = 16;
  localparam int unsigned MatAddrW        = 4;

  // normalized magnitudes keep this many bits before squaring
  localparam int unsigned ScaledBits = 30;

  // matrix select codes
  localparam logic SelProjection = 1'b0;
  localparam logic SelModelview  = 1'b1;

  // plane codes
  localparam logic [2:0] PlaneRight  = 3'd0;
  localparam logic [2:0] PlaneLeft   = 3'd1;
  localparam logic [2:0] PlaneBottom = 3'd2;
  localparam logic [2:0] PlaneTop    = 3'd3;
  localparam logic [2:0] PlaneFar    = 3'd4;
  localparam logic [2:0] PlaneNear   = 3'd5;
  localparam logic [2:0] LastPlane   = PlaneNear;

  // clip matrix column codes
  localparam logic [1:0] ColX = 2'd0;
  localparam logic [1:0] ColY = 2'd1;
  localparam logic [1:0] ColZ = 2'd2;
  localparam logic [1:0] ColW = 2'd3;

  typedef struct packed {
    logic                        matrix_select;
    logic [MatAddrW-1:0]         element_index;
    logic signed [ElemWidth-1:0] element_value;
    logic                        compute_now;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]                  plane_index;
    logic signed [CoefWidth-1:0] coef_a;
    logic signed [CoefWidth-1:0] coef_b;
    logic signed [CoefWidth-1:0] coef_c;
    logic signed [CoefWidth-1:0] coef_d;
    logic                        degenerate;
    logic                        last_plane;
  } out_beat_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_CLIP,
    TOP_PLANE,
    TOP_WAIT
  } top_state_e;

  typedef enum logic [2:0] {
    NORM_IDLE,
    NORM_SHIFT,
    NORM_SQUARE,
    NORM_ROOT,
    NORM_DIVIDE,
    NORM_DONE
  } norm_state_e;

  // column combined with the w column for each plane
  function automatic logic [1:0] plane_col(input logic [2:0] pl);
    logic [1:0] col;
    unique case (pl)
      PlaneRight, PlaneLeft: col = ColX;
      PlaneBottom, PlaneTop: col = ColY;
      default:               col = ColZ;
    endcase
    return col;
  endfunction

  // plane takes w minus the column instead of w plus it
  function automatic logic plane_sub(input logic [2:0] pl);
    logic sub;
    unique case (pl)
      PlaneRight, PlaneTop, PlaneFar: sub = 1'b1;
      default:                        sub = 1'b0;
    endcase
    return sub;
  endfunction

endpackage

// ===== rtl/core/fpe_ram.sv =====
`timescale 1ns / 1ps

module fpe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/fpe_clip.sv =====
`timescale 1ns / 1ps

module fpe_clip #(
  parameter int unsigned FRAC_BITS = fpe_pkg::FracBitsDefault,
  localparam int unsigned ClipW = 2 * fpe_pkg::ElemWidth + 2 - FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  rd_en_o,
  output logic [fpe_pkg::MatAddrW-1:0]          mv_addr_o,
  output logic [fpe_pkg::MatAddrW-1:0]          pj_addr_o,
  input  logic signed [fpe_pkg::ElemWidth-1:0]  mv_data_i,
  input  logic signed [fpe_pkg::ElemWidth-1:0]  pj_data_i,
  output logic                                  done_o,
  output logic signed [ClipW-1:0]               clip_o [4][4]
);

  localparam int unsigned ProdW = 2 * fpe_pkg::ElemWidth;

  logic                    busy_q;
  logic [5:0]              cnt_q;
  logic                    v1_q, v2_q, done_q;
  logic [5:0]              tag1_q, tag2_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ClipW-1:0] acc_q;
  logic signed [ClipW-1:0] clip_q [4][4];

  logic signed [ProdW-1-FRAC_BITS:0] prod_sh;
  logic signed [ClipW-1:0]           acc_sum;

  // issue order: row, column, then the inner index
  assign rd_en_o   = busy_q;
  assign mv_addr_o = {cnt_q[5:4], cnt_q[1:0]};
  assign pj_addr_o = {cnt_q[1:0], cnt_q[3:2]};

  // floored product summed into the running entry
  assign prod_sh = prod_q[ProdW-1:FRAC_BITS];
  assign acc_sum = ((tag2_q[1:0] == 2'd0) ? '0 : acc_q) + ClipW'(prod_sh);

  // read sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= busy_q;
      v2_q   <= v1_q;
      done_q <= v2_q && (tag2_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // multiply and accumulate
  always_ff @(posedge clk_i) begin
    tag1_q <= cnt_q;
    tag2_q <= tag1_q;
    prod_q <= mv_data_i * pj_data_i;
    if (v2_q) begin
      acc_q <= acc_sum;
      if (tag2_q[1:0] == 2'd3) begin
        clip_q[tag2_q[5:4]][tag2_q[3:2]] <= acc_sum;
      end
    end
  end

  assign done_o = done_q;
  assign clip_o = clip_q;

endmodule

// ===== rtl/core/fpe_norm.sv =====
`timescale 1ns / 1ps

module fpe_norm #(
  parameter int unsigned FRAC_BITS = fpe_pkg::FracBitsDefault,
  localparam int unsigned PlaneW = 2 * fpe_pkg::ElemWidth + 3 - FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [2:0]                plane_i,
  input  logic signed [PlaneW-1:0]  comp_i [4],
  input  logic                      ack_i,
  output logic                      done_o,
  output fpe_pkg::out_beat_t        res_o
);

  localparam int unsigned MagW  = PlaneW;
  localparam int unsigned SB    = fpe_pkg::ScaledBits;
  localparam int unsigned CW    = fpe_pkg::CoefWidth;
  localparam int unsigned CntW  = $clog2(MagW);
  localparam int unsigned StepW = $clog2(FRAC_BITS + SB + MagW);
  localparam int unsigned RootW = 2 * SB + 2;
  localparam int unsigned RootIW = $clog2(SB + 1);
  localparam int unsigned LenW  = SB + 1;
  localparam int unsigned QW    = CW + 1;

  fpe_pkg::norm_state_e state_q, state_d;

  logic [MagW-1:0]   mag_q [4];
  logic [3:0]        neg_q;
  logic [MagW-1:0]   sh_q [3];
  logic [CntW-1:0]   cnt_q;
  logic [1:0]        sq_j_q;
  logic [RootW-1:0]  sq_acc_q;
  logic [RootW-1:0]  n_q, res_q;
  logic [RootIW-1:0] root_i_q;
  logic [1:0]        coef_j_q;
  logic [StepW-1:0]  steps_q, step_q;
  logic [LenW-1:0]   rem_q;
  logic [MagW-1:0]   fd_q;
  logic [QW-1:0]     q_q;
  logic              big_q;
  logic [CW-1:0]     coef_q [4];
  logic              degen_q;
  logic [2:0]        plane_q;

  logic [MagW-1:0]   in_mag [4];
  logic [3:0]        in_neg;
  logic              in_zero;
  logic              top_set;
  logic [MagW-1:0]   sh_sel;
  logic [SB-1:0]     sq_a;
  logic [2*SB-1:0]   sq_prod;
  logic [RootW-1:0]  sq_sum;
  logic [RootW-1:0]  root_bit;
  logic [RootW:0]    root_try;
  logic              root_ge;
  logic [LenW-1:0]   len_w;
  logic [LenW:0]     div_r2, div_sub;
  logic              div_ge;
  logic [LenW-1:0]   rem_next;
  logic [QW-1:0]     q_next, cap, mq;
  logic              big_next, sat, neg_sel;
  logic [CW-1:0]     coef_val;
  logic              step_last;

  // magnitudes and signs of the incoming plane
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      in_neg[j] = comp_i[j][PlaneW-1];
      in_mag[j] = in_neg[j] ? MagW'(-comp_i[j]) : MagW'(comp_i[j]);
    end
    in_zero = ~|(in_mag[0] | in_mag[1] | in_mag[2]);
  end

  assign top_set = sh_q[0][MagW-1] | sh_q[1][MagW-1] | sh_q[2][MagW-1];

  // sum of squares, one term a cycle
  always_comb begin
    unique case (sq_j_q)
      2'd0:    sh_sel = sh_q[0];
      2'd1:    sh_sel = sh_q[1];
      default: sh_sel = sh_q[2];
    endcase
  end
  assign sq_a    = sh_sel[MagW-1 -: SB];
  assign sq_prod = sq_a * sq_a;
  assign sq_sum  = sq_acc_q + RootW'(sq_prod);

  // integer square root step
  assign root_bit = RootW'(1) << (2 * root_i_q);
  assign root_try = {1'b0, res_q} + {1'b0, root_bit};
  assign root_ge  = {1'b0, n_q} >= root_try;

  // restoring division step
  assign len_w     = (res_q[LenW-1:0] == '0) ? LenW'(1) : res_q[LenW-1:0];
  assign div_r2    = {rem_q, fd_q[MagW-1]};
  assign div_ge    = div_r2 >= {1'b0, len_w};
  assign div_sub   = div_r2 - {1'b0, len_w};
  assign rem_next  = div_ge ? div_sub[LenW-1:0] : div_r2[LenW-1:0];
  assign q_next    = {q_q[QW-2:0], div_ge};
  assign big_next  = big_q | q_q[QW-1];
  assign step_last = (step_q == StepW'(1));

  // saturate and apply the sign
  assign neg_sel  = neg_q[coef_j_q];
  assign cap      = (QW'(1) << (CW - 1)) - QW'(!neg_sel);
  assign sat      = big_next || (q_next > cap);
  assign mq       = sat ? cap : q_next;
  assign coef_val = neg_sel ? CW'(-mq) : CW'(mq);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpe_pkg::NORM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpe_pkg::NORM_IDLE: begin
        if (start_i) begin
          state_d = in_zero ? fpe_pkg::NORM_DONE : fpe_pkg::NORM_SHIFT;
        end
      end
      fpe_pkg::NORM_SHIFT: begin
        if (top_set) begin
          state_d = fpe_pkg::NORM_SQUARE;
        end
      end
      fpe_pkg::NORM_SQUARE: begin
        if (sq_j_q == 2'd2) begin
          state_d = fpe_pkg::NORM_ROOT;
        end
      end
      fpe_pkg::NORM_ROOT: begin
        if (root_i_q == '0) begin
          state_d = fpe_pkg::NORM_DIVIDE;
        end
      end
      fpe_pkg::NORM_DIVIDE: begin
        if (step_last && (coef_j_q == 2'd3)) begin
          state_d = fpe_pkg::NORM_DONE;
        end
      end
      fpe_pkg::NORM_DONE: begin
        if (ack_i) begin
          state_d = fpe_pkg::NORM_IDLE;
        end
      end
      default: state_d = fpe_pkg::NORM_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fpe_pkg::NORM_IDLE: begin
        if (start_i) begin
          for (int j = 0; j < 4; j++) begin
            mag_q[j]  <= in_mag[j];
            coef_q[j] <= '0;
          end
          for (int j = 0; j < 3; j++) begin
            sh_q[j] <= in_mag[j];
          end
          neg_q    <= in_neg;
          degen_q  <= in_zero;
          plane_q  <= plane_i;
          cnt_q    <= '0;
          sq_j_q   <= '0;
          sq_acc_q <= '0;
        end
      end
      fpe_pkg::NORM_SHIFT: begin
        if (!top_set) begin
          for (int j = 0; j < 3; j++) begin
            sh_q[j] <= sh_q[j] << 1;
          end
          cnt_q <= cnt_q + CntW'(1);
        end
        steps_q <= StepW'(FRAC_BITS + SB) + StepW'(cnt_q);
      end
      fpe_pkg::NORM_SQUARE: begin
        sq_acc_q <= sq_sum;
        sq_j_q   <= sq_j_q + 2'd1;
        if (sq_j_q == 2'd2) begin
          n_q      <= sq_sum;
          res_q    <= '0;
          root_i_q <= RootIW'(SB);
        end
      end
      fpe_pkg::NORM_ROOT: begin
        if (root_ge) begin
          n_q   <= n_q - root_try[RootW-1:0];
          res_q <= (res_q >> 1) + root_bit;
        end else begin
          res_q <= res_q >> 1;
        end
        root_i_q <= root_i_q - RootIW'(1);
        coef_j_q <= '0;
        rem_q    <= '0;
        q_q      <= '0;
        big_q    <= 1'b0;
        fd_q     <= mag_q[0];
        step_q   <= steps_q;
      end
      fpe_pkg::NORM_DIVIDE: begin
        rem_q  <= rem_next;
        q_q    <= q_next;
        big_q  <= big_next;
        fd_q   <= fd_q << 1;
        step_q <= step_q - StepW'(1);
        if (step_last) begin
          coef_q[coef_j_q] <= coef_val;
          coef_j_q         <= coef_j_q + 2'd1;
          rem_q            <= '0;
          q_q              <= '0;
          big_q            <= 1'b0;
          fd_q             <= mag_q[2'(coef_j_q + 2'd1)];
          step_q           <= steps_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign done_o            = (state_q == fpe_pkg::NORM_DONE);
  assign res_o.plane_index = plane_q;
  assign res_o.coef_a      = coef_q[0];
  assign res_o.coef_b      = coef_q[1];
  assign res_o.coef_c      = coef_q[2];
  assign res_o.coef_d      = coef_q[3];
  assign res_o.degenerate  = degen_q;
  assign res_o.last_plane  = (plane_q == fpe_pkg::LastPlane);

endmodule

// ===== rtl/core/frustum_plane_extractor_unit.sv =====
`timescale 1ns / 1ps

// Frustum plane extractor.
// Input channel (in_valid_i / in_ready_o / in_data_i): each beat writes one
// Q16.16 element of the projection or modelview matrix. A beat without
// compute_now is taken at once and leaves the block idle and ready for more.
// A beat with compute_now forms clip = modelview * projection and then sends
// six plane beats (right, left, bottom, top, far, near) on the output channel
// (out_valid_o / out_ready_i / out_data_o), the last with last_plane set.
// The clip product uses one multiplier over 64 reads of the two matrix
// memories. Each plane then passes through the normalizer: a left shift by
// s (1 to 50 at FRAC_BITS = 16) that normalizes the largest normal component,
// the sum of squares, an integer square root and one division per
// coefficient; the divider produces one quotient bit a cycle.
// Input is taken only while no extraction is running.
// Reset clears the entry valid bits so both matrices read as all zero.
// If the receiver stalls, the finished plane waits in the output register
// and the normalizer holds the next one; nothing is dropped.
module frustum_plane_extractor_unit #(
  parameter int unsigned FRAC_BITS = fpe_pkg::FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fpe_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fpe_pkg::out_beat_t  out_data_o
);

  localparam int unsigned ClipW  = 2 * fpe_pkg::ElemWidth + 2 - FRAC_BITS;
  localparam int unsigned PlaneW = ClipW + 1;
  localparam int unsigned EW     = fpe_pkg::ElemWidth;
  localparam int unsigned AW     = fpe_pkg::MatAddrW;
  localparam int unsigned Depth  = fpe_pkg::MatDepth;

  fpe_pkg::top_state_e state_q, state_d;

  logic                    in_fire;
  logic                    clip_start, clip_done, rd_en;
  logic [AW-1:0]           mv_addr, pj_addr;
  logic [EW-1:0]           mv_rdata, pj_rdata;
  logic signed [EW-1:0]    mv_data, pj_data;
  logic [Depth-1:0]        mv_vld_q, pj_vld_q;
  logic                    mv_ok_q, pj_ok_q;
  logic signed [ClipW-1:0] clip [4][4];
  logic [2:0]              pl_q;
  logic signed [PlaneW-1:0] comp [4];
  logic                    norm_start, norm_done, norm_ack;
  fpe_pkg::out_beat_t      norm_res;
  logic                    out_vld_q;
  fpe_pkg::out_beat_t      out_q;
  logic                    mv_we, pj_we;

  assign in_ready_o = (state_q == fpe_pkg::TOP_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign clip_start = in_fire && in_data_i.compute_now;
  assign mv_we      = in_fire && (in_data_i.matrix_select == fpe_pkg::SelModelview);
  assign pj_we      = in_fire && (in_data_i.matrix_select == fpe_pkg::SelProjection);

  // matrix memories
  fpe_ram #(.WIDTH(EW), .DEPTH(Depth)) u_mv_ram (
    .clk_i   (clk_i),
    .we_i    (mv_we),
    .waddr_i (in_data_i.element_index),
    .wdata_i (in_data_i.element_value),
    .re_i    (rd_en),
    .raddr_i (mv_addr),
    .rdata_o (mv_rdata)
  );

  fpe_ram #(.WIDTH(EW), .DEPTH(Depth)) u_pj_ram (
    .clk_i   (clk_i),
    .we_i    (pj_we),
    .waddr_i (in_data_i.element_index),
    .wdata_i (in_data_i.element_value),
    .re_i    (rd_en),
    .raddr_i (pj_addr),
    .rdata_o (pj_rdata)
  );

  // entry valid bits, unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_vld_q <= '0;
      pj_vld_q <= '0;
      mv_ok_q  <= 1'b0;
      pj_ok_q  <= 1'b0;
    end else begin
      if (mv_we) begin
        mv_vld_q[in_data_i.element_index] <= 1'b1;
      end
      if (pj_we) begin
        pj_vld_q[in_data_i.element_index] <= 1'b1;
      end
      if (rd_en) begin
        mv_ok_q <= mv_vld_q[mv_addr];
        pj_ok_q <= pj_vld_q[pj_addr];
      end
    end
  end

  assign mv_data = mv_ok_q ? mv_rdata : '0;
  assign pj_data = pj_ok_q ? pj_rdata : '0;

  fpe_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (clip_start),
    .rd_en_o   (rd_en),
    .mv_addr_o (mv_addr),
    .pj_addr_o (pj_addr),
    .mv_data_i (mv_data),
    .pj_data_i (pj_data),
    .done_o    (clip_done),
    .clip_o    (clip)
  );

  // plane components: w column plus or minus the selected column
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      logic signed [PlaneW-1:0] base, other;
      base = PlaneW'(clip[r][fpe_pkg::ColW]);
      unique case (fpe_pkg::plane_col(pl_q))
        fpe_pkg::ColX: other = PlaneW'(clip[r][fpe_pkg::ColX]);
        fpe_pkg::ColY: other = PlaneW'(clip[r][fpe_pkg::ColY]);
        default:       other = PlaneW'(clip[r][fpe_pkg::ColZ]);
      endcase
      comp[r] = fpe_pkg::plane_sub(pl_q) ? (base - other) : (base + other);
    end
  end

  fpe_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .plane_i (pl_q),
    .comp_i  (comp),
    .ack_i   (norm_ack),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  assign norm_start = (state_q == fpe_pkg::TOP_PLANE);
  assign norm_ack   = (state_q == fpe_pkg::TOP_WAIT) && norm_done &&
                      (!out_vld_q || out_ready_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpe_pkg::TOP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpe_pkg::TOP_IDLE: begin
        if (clip_start) begin
          state_d = fpe_pkg::TOP_CLIP;
        end
      end
      fpe_pkg::TOP_CLIP: begin
        if (clip_done) begin
          state_d = fpe_pkg::TOP_PLANE;
        end
      end
      fpe_pkg::TOP_PLANE: state_d = fpe_pkg::TOP_WAIT;
      fpe_pkg::TOP_WAIT: begin
        if (norm_ack) begin
          state_d = (pl_q == fpe_pkg::LastPlane) ? fpe_pkg::TOP_IDLE : fpe_pkg::TOP_PLANE;
        end
      end
      default: state_d = fpe_pkg::TOP_IDLE;
    endcase
  end

  // plane counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q      <= fpe_pkg::PlaneRight;
      out_vld_q <= 1'b0;
    end else begin
      if (clip_done) begin
        pl_q <= fpe_pkg::PlaneRight;
      end else if (norm_ack) begin
        pl_q <= pl_q + 3'd1;
      end
      if (norm_ack) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (norm_ack) begin
      out_q <= norm_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/fpe_checker.sv =====
`timescale 1ns / 1ps

module fpe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input fpe_pkg::in_beat_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input fpe_pkg::out_beat_t out_data_o
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // last flag marks the near plane only
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_plane == (out_data_o.plane_index == fpe_pkg::LastPlane)))
    else $error("last_plane does not match plane index");

  // degenerate planes carry zero coefficients
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      (out_data_o.coef_a == '0) && (out_data_o.coef_b == '0) &&
      (out_data_o.coef_c == '0) && (out_data_o.coef_d == '0))
    else $error("degenerate plane with nonzero coefficients");

  // a compute beat starts an extraction that blocks input
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.compute_now |=> !in_ready_o)
    else $error("input taken right after a compute beat");

endmodule

bind frustum_plane_extractor_unit fpe_checker u_fpe_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fpe_pkg::*;

  localparam int unsigned FracBits  = FracBitsDefault;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 3500;
  localparam logic signed [31:0] OneQ = 32'sh0001_0000;

  // scoreboard: keeps its own copy of both matrices and the planes still owed
  class plane_scoreboard;
    longint proj_m[16];
    longint view_m[16];
    out_beat_t planes_q[$];
    int errors;
    int n_results;
    int n_degenerate;
    int n_saturated;

    function new();
      foreach (proj_m[i]) begin
        proj_m[i] = 0;
        view_m[i] = 0;
      end
      errors = 0;
      n_results = 0;
      n_degenerate = 0;
      n_saturated = 0;
    endfunction

    function longint unsigned magnitude(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // floor(mag * 2^k / den), clamped to cap
    function longint unsigned quotient_sat(longint unsigned mag, int k,
                                           longint unsigned den,
                                           longint unsigned cap);
      longint unsigned q;
      longint unsigned r;
      q = mag / den;
      r = mag % den;
      if (k < 0) begin
        q = q >> (-k);
        return q > cap ? cap : q;
      end
      if (q > cap) return cap;
      for (int i = 0; i < k; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
        if (q > cap) return cap;
      end
      return q;
    endfunction

    // normalize one plane into an output beat
    function out_beat_t normalize_plane(longint p[4], logic [2:0] pl);
      out_beat_t o;
      longint unsigned m, sq, len, a, q, cap;
      int b, e;
      logic neg;
      logic [31:0] coef[4];
      o = '0;
      o.plane_index = pl;
      o.last_plane = (pl == PlaneNear);
      m = 0;
      sq = 0;
      for (int j = 0; j < 3; j++)
        if (magnitude(p[j]) > m) m = magnitude(p[j]);
      if (m == 0) begin
        o.degenerate = 1'b1;
        return o;
      end
      b = 0;
      while (b < 64 && (m >> b) != 0) b++;
      e = ScaledBits - b;
      for (int j = 0; j < 3; j++) begin
        a = magnitude(p[j]);
        a = (e >= 0) ? (a << e) : (a >> (-e));
        sq = sq + a * a;
      end
      len = int_sqrt(sq);
      if (len == 0) len = 1;
      for (int j = 0; j < 4; j++) begin
        neg = p[j] < 0;
        cap = neg ? (64'd1 << (CoefWidth - 1)) : ((64'd1 << (CoefWidth - 1)) - 1);
        q = quotient_sat(magnitude(p[j]), FracBits + e, len, cap);
        if (q == cap) n_saturated++;
        coef[j] = neg ? 32'(longint'(0) - q) : 32'(q);
      end
      o.coef_a = coef[0];
      o.coef_b = coef[1];
      o.coef_c = coef[2];
      o.coef_d = coef[3];
      return o;
    endfunction

    // accepted input beat: store the element, predict planes on compute
    function void note_write(in_beat_t w);
      longint clip[16];
      longint s, p[4];
      logic [1:0] col;
      logic sub;
      if (w.matrix_select == SelModelview) view_m[w.element_index] = w.element_value;
      else proj_m[w.element_index] = w.element_value;
      if (!w.compute_now) return;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          s = 0;
          for (int k = 0; k < 4; k++)
            s = s + ((view_m[r*4+k] * proj_m[k*4+c]) >>> FracBits);
          clip[r*4+c] = s;
        end
      for (int pl = PlaneRight; pl <= PlaneNear; pl++) begin
        case (3'(pl))
          PlaneRight:  begin col = ColX; sub = 1'b1; end
          PlaneLeft:   begin col = ColX; sub = 1'b0; end
          PlaneBottom: begin col = ColY; sub = 1'b0; end
          PlaneTop:    begin col = ColY; sub = 1'b1; end
          PlaneFar:    begin col = ColZ; sub = 1'b1; end
          default:     begin col = ColZ; sub = 1'b0; end
        endcase
        for (int r = 0; r < 4; r++)
          p[r] = sub ? clip[r*4+ColW] - clip[r*4+col] : clip[r*4+ColW] + clip[r*4+col];
        planes_q.push_back(normalize_plane(p, 3'(pl)));
      end
    endfunction

    // accepted output beat against the oldest owed plane
    function void check_plane(out_beat_t got);
      out_beat_t exp_b;
      n_results++;
      if (planes_q.size() == 0) begin
        $display("%0t: unexpected plane beat %p", $realtime, got);
        errors++;
        return;
      end
      exp_b = planes_q.pop_front();
      if (exp_b.degenerate) n_degenerate++;
      if (got.plane_index !== exp_b.plane_index) begin
        $display("%0t: plane_index exp %0d got %0d", $realtime, exp_b.plane_index,
                 got.plane_index);
        errors++;
      end
      if (got.coef_a !== exp_b.coef_a) begin
        $display("%0t: coef_a exp %h got %h", $realtime, exp_b.coef_a, got.coef_a);
        errors++;
      end
      if (got.coef_b !== exp_b.coef_b) begin
        $display("%0t: coef_b exp %h got %h", $realtime, exp_b.coef_b, got.coef_b);
        errors++;
      end
      if (got.coef_c !== exp_b.coef_c) begin
        $display("%0t: coef_c exp %h got %h", $realtime, exp_b.coef_c, got.coef_c);
        errors++;
      end
      if (got.coef_d !== exp_b.coef_d) begin
        $display("%0t: coef_d exp %h got %h", $realtime, exp_b.coef_d, got.coef_d);
        errors++;
      end
      if (got.degenerate !== exp_b.degenerate) begin
        $display("%0t: degenerate exp %b got %b", $realtime, exp_b.degenerate,
                 got.degenerate);
        errors++;
      end
      if (got.last_plane !== exp_b.last_plane) begin
        $display("%0t: last_plane exp %b got %b", $realtime, exp_b.last_plane,
                 got.last_plane);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  plane_scoreboard sb = new();
  int tx_idle_pct = 29;
  int rx_idle_pct = 84;
  int n_items = 0;
  int stall_cnt = 0;

  frustum_plane_extractor_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) sb.check_plane(out_data);
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one element write, with a random gap before it
  task automatic write_elem(logic sel, logic [3:0] idx, logic signed [31:0] val,
                            logic go);
    in_beat_t w;
    w.matrix_select = sel;
    w.element_index = idx;
    w.element_value = val;
    w.compute_now = go;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_write(w);
    n_items++;
    // idle mix moves with progress
    if (n_items == 107) begin
      tx_idle_pct = 84;
      rx_idle_pct = 29;
    end else if (n_items == 214) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  function automatic logic signed [31:0] rand_elem();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom_range(524288) - 262144;
    if (pick < 65) return $urandom;
    if (pick < 75) return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    if (pick < 90) return 0;
    return $urandom_range(1) ? OneQ : -OneQ;
  endfunction

  initial begin
    int len;
    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // both matrices zero: every plane has a zero normal
    write_elem(SelProjection, 4'd0, 0, 1'b1);
    // identities
    for (int i = 0; i < 4; i++) write_elem(SelProjection, 4'(i*5), OneQ, i == 3);
    for (int i = 0; i < 4; i++) write_elem(SelModelview, 4'(i*5), OneQ, i == 3);
    // tiny normals against a huge offset drive the coefficients into saturation
    write_elem(SelModelview, 4'd15, 32'sh7fff_ffff, 1'b1);
    write_elem(SelModelview, 4'd0, 1, 1'b0);
    write_elem(SelModelview, 4'd5, 1, 1'b0);
    write_elem(SelModelview, 4'd10, 1, 1'b1);
    write_elem(SelModelview, 4'd15, 32'sh8000_0000, 1'b1);
    write_elem(SelModelview, 4'd0, 32'sh8000_0000, 1'b1);
    write_elem(SelProjection, 4'd15, 32'sh7fff_ffff, 1'b1);
    write_elem(SelProjection, 4'd3, -OneQ, 1'b1);

    // random frames: a burst of writes closed by a compute, plus stray writes
    while (n_items < 320) begin
      if (n_items >= 150 && n_items < 160 && sb.planes_q.size() != 0) begin
        // hold off until the block has delivered everything owed
        in_valid <= 1'b0;
        while (sb.planes_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          write_elem(1'($urandom), 4'($urandom), rand_elem(), i == len - 1);
      end else begin
        write_elem(1'($urandom), 4'($urandom), $urandom, 1'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.planes_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d element writes, %0d plane beats checked (%0d zero-normal, %0d clamped coefs)",
             n_items, sb.n_results, sb.n_degenerate, sb.n_saturated);
    $display("idle mixes: sender-heavy, receiver-heavy, none; one full drain hold-off");
    if (sb.errors == 0 && sb.planes_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/fpe_pkg.sv
rtl/core/fpe_ram.sv
rtl/core/fpe_clip.sv
rtl/core/fpe_norm.sv
rtl/core/frustum_plane_extractor_unit.sv
rtl/core/fpe_checker.sv
bench/tb.sv
